// ===== rtl/bgq_pkg.sv =====
// Beat grid quantizer package: default parameters, register limits, codes.
// Used by bgq_period_div, beat_grid_quantizer_core and bgq_checker; depends on nothing.
package bgq_pkg;

  localparam int POSITION_WIDTH = 48;
  localparam int FRACTION_BITS  = 16;
  localparam int BEATS_PER_BAR  = 4;

  localparam int TEMPO_W      = 25;
  localparam int TEMPO_FRAC   = 16;
  localparam int RATE_W       = 19;
  localparam int RATE_PROD_W  = 25;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDE_W       = 66;

  localparam logic [TEMPO_W-1:0]     TEMPO_MIN     = TEMPO_W'(20 << TEMPO_FRAC);
  localparam logic [TEMPO_W-1:0]     TEMPO_MAX     = TEMPO_W'(300 << TEMPO_FRAC);
  localparam logic [TEMPO_W-1:0]     TEMPO_RESET   = TEMPO_W'(120 << TEMPO_FRAC);
  localparam logic [RATE_W-1:0]      RATE_DEFAULT  = RATE_W'(44100);
  localparam logic [RATE_PROD_W-1:0] RATE_MULT     = RATE_PROD_W'(60);
  localparam int                     PERIOD_RESET_SAMPLES = 22050;

  localparam logic signed [WIDE_W-1:0] I64_HI = {3'b000, {63{1'b1}}};
  localparam logic signed [WIDE_W-1:0] I64_LO = {3'b111, {63{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO  = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_BAR         = 2'd0,
    MODE_BEAT        = 2'd1,
    MODE_BAR_IDX     = 2'd2,
    MODE_BEAT_IN_BAR = 2'd3
  } mode_t;

endpackage

// ===== rtl/bgq_div_cell.sv =====
// One restoring-division cell: one quotient bit, remainder and bar-count residue.
// Chained by the top level; no package dependencies.
module bgq_div_cell #(
  parameter int NQ  = 64,
  parameter int PPW = 39,
  parameter int MB  = 2,
  parameter int BPB = 4,
  parameter int SBW = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             prev_vld,
  input  logic [PPW-1:0]   prev_rem,
  input  logic [NQ-1:0]    prev_sh,
  input  logic [MB-1:0]    prev_qm,
  input  logic [PPW-1:0]   prev_period,
  input  logic [SBW-1:0]   prev_side,
  output logic             next_vld,
  output logic [PPW-1:0]   next_rem,
  output logic [NQ-1:0]    next_sh,
  output logic [MB-1:0]    next_qm,
  output logic [PPW-1:0]   next_period,
  output logic [SBW-1:0]   next_side
);

  logic [PPW:0]   trial;
  logic [PPW:0]   diff;
  logic           take;
  logic [MB:0]    qm2;
  logic           vld_r;
  logic [PPW-1:0] rem_r, rem_nxt;
  logic [NQ-1:0]  sh_r, sh_nxt;
  logic [MB-1:0]  qm_r, qm_nxt;
  logic [PPW-1:0] period_r;
  logic [SBW-1:0] side_r;

  always_comb begin
    trial   = {prev_rem, prev_sh[NQ-1]};
    diff    = trial - {1'b0, prev_period};
    take    = trial >= {1'b0, prev_period};
    rem_nxt = take ? diff[PPW-1:0] : trial[PPW-1:0];
    sh_nxt  = {prev_sh[NQ-2:0], take};
    qm2     = {prev_qm, take};
    if (qm2 >= (MB+1)'(BPB)) begin
      qm_nxt = MB'(qm2 - (MB+1)'(BPB));
    end else begin
      qm_nxt = qm2[MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    sh_r     <= sh_nxt;
    qm_r     <= qm_nxt;
    period_r <= prev_period;
    side_r   <= prev_side;
  end

  assign next_vld    = vld_r;
  assign next_rem    = rem_r;
  assign next_sh     = sh_r;
  assign next_qm     = qm_r;
  assign next_period = period_r;
  assign next_side   = side_r;

endmodule

// ===== rtl/bgq_period_div.sv =====
// Samples-per-beat unit: bit-serial division of rate * 60 by the Q16 tempo.
// Depends on bgq_pkg.
module bgq_period_div #(
  parameter int FRACTION_BITS = bgq_pkg::FRACTION_BITS,
  parameter int PW            = 21 + bgq_pkg::FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           recalc,
  input  logic [bgq_pkg::TEMPO_W-1:0]    tempo,
  input  logic [bgq_pkg::RATE_W-1:0]     rate,
  output logic                           busy,
  output logic [PW-1:0]                  period
);

  localparam int DW   = bgq_pkg::RATE_PROD_W + bgq_pkg::TEMPO_FRAC + FRACTION_BITS;
  localparam int CNTW = $clog2(DW);
  localparam logic [PW-1:0] PERIOD_RST =
    PW'(bgq_pkg::PERIOD_RESET_SAMPLES) << FRACTION_BITS;

  logic                          pend_r, pend_nxt;
  logic                          run_r, run_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic [bgq_pkg::TEMPO_W-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]                 sh_r, sh_nxt;
  logic [PW-1:0]                 period_r, period_nxt;
  logic [bgq_pkg::TEMPO_W:0]     trial;
  logic [bgq_pkg::TEMPO_W:0]     diff;
  logic                          take;
  logic [bgq_pkg::RATE_PROD_W-1:0] prod;

  always_comb begin
    prod       = bgq_pkg::RATE_PROD_W'(rate) * bgq_pkg::RATE_MULT;
    trial      = {rem_r, sh_r[DW-1]};
    diff       = trial - {1'b0, tempo};
    take       = trial >= {1'b0, tempo};
    pend_nxt   = pend_r;
    run_nxt    = run_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    sh_nxt     = sh_r;
    period_nxt = period_r;
    priority if (recalc) begin
      pend_nxt = 1'b1;
      run_nxt  = 1'b0;
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      sh_nxt   = {prod, {(bgq_pkg::TEMPO_FRAC + FRACTION_BITS){1'b0}}};
    end else if (run_r) begin
      rem_nxt = take ? diff[bgq_pkg::TEMPO_W-1:0] : trial[bgq_pkg::TEMPO_W-1:0];
      sh_nxt  = {sh_r[DW-2:0], take};
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(DW - 1)) begin
        run_nxt    = 1'b0;
        period_nxt = sh_nxt[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      run_r    <= 1'b0;
      cnt_r    <= '0;
      period_r <= PERIOD_RST;
    end else begin
      pend_r   <= pend_nxt;
      run_r    <= run_nxt;
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy   = pend_r | run_r;
  assign period = period_r;

endmodule

// ===== rtl/beat_grid_quantizer_core.sv =====
// Beat grid quantizer top level: configuration registers, entry stage, division
// chain of bgq_div_cell, result stages. Depends on bgq_pkg, bgq_div_cell, bgq_period_div.
//
//  channel  | ports                                    | transfer
//  input    | start, busy, in_mode, in_sample_position | start high, busy low
//  result   | out_valid, out_grid_value                | out_valid high, one cycle
//  config   | cfg_we, cfg_index, cfg_wdata             | cfg_we high
//
// One item a cycle while busy is low; out_valid follows the accepting edge through
// the entry stage, one division cell per quotient bit, and stages A, B and C.
// A tempo or rate write keeps busy high while the bit-serial period division is
// pending and runs. Synchronous reset clears valids, configuration and period registers.
// The receiver cannot stall; results leave on the cycle they are produced.
module beat_grid_quantizer_core #(
  parameter int POSITION_WIDTH = bgq_pkg::POSITION_WIDTH,
  parameter int FRACTION_BITS  = bgq_pkg::FRACTION_BITS,
  parameter int BEATS_PER_BAR  = bgq_pkg::BEATS_PER_BAR
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_mode,
  input  logic signed [POSITION_WIDTH-1:0]     in_sample_position,
  output logic                                 out_valid,
  output logic signed [POSITION_WIDTH-1:0]     out_grid_value,
  input  logic                                 cfg_we,
  input  logic [bgq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [POSITION_WIDTH-1:0]            cfg_wdata
);

  localparam int W    = POSITION_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int XW   = bgq_pkg::WIDE_W;
  localparam int PW   = 21 + F;
  localparam int PPW  = PW + $clog2(BEATS_PER_BAR);
  localparam int NQ   = W + F;
  localparam int MB   = $clog2(BEATS_PER_BAR);
  localparam int RW   = (W < 64) ? W + 1 : 64;
  localparam int SBW  = 2 + W + RW + 1;
  localparam int QSW  = (NQ < 63) ? NQ : 63;
  localparam int QXW  = (NQ > 64) ? NQ : 64;
  localparam int DQW  = PPW - F;
  localparam logic [MB-1:0] QSAT_MOD =
    MB'(64'h7fff_ffff_ffff_ffff % 64'(BEATS_PER_BAR));
  localparam logic signed [XW-1:0] POS_HI = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] POS_LO = ~POS_HI;

  // configuration
  logic [bgq_pkg::TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [bgq_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic signed [W-1:0]         offset_r, offset_nxt;
  logic                        recalc;
  logic [PW-1:0]               period;
  logic                        pdiv_busy;

  always_comb begin
    tempo_nxt  = tempo_r;
    rate_nxt   = rate_r;
    offset_nxt = offset_r;
    recalc     = 1'b0;
    if (cfg_we) begin
      unique case (bgq_pkg::cfg_idx_t'(cfg_index))
        bgq_pkg::CFG_TEMPO: begin
          recalc = 1'b1;
          if (cfg_wdata[bgq_pkg::TEMPO_W-1:0] < bgq_pkg::TEMPO_MIN) begin
            tempo_nxt = bgq_pkg::TEMPO_MIN;
          end else if (cfg_wdata[bgq_pkg::TEMPO_W-1:0] > bgq_pkg::TEMPO_MAX) begin
            tempo_nxt = bgq_pkg::TEMPO_MAX;
          end else begin
            tempo_nxt = cfg_wdata[bgq_pkg::TEMPO_W-1:0];
          end
        end
        bgq_pkg::CFG_RATE: begin
          recalc = 1'b1;
          if (cfg_wdata[bgq_pkg::RATE_W-1:0] == '0) begin
            rate_nxt = bgq_pkg::RATE_DEFAULT;
          end else begin
            rate_nxt = cfg_wdata[bgq_pkg::RATE_W-1:0];
          end
        end
        bgq_pkg::CFG_OFFSET: begin
          offset_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r  <= bgq_pkg::TEMPO_RESET;
      rate_r   <= bgq_pkg::RATE_DEFAULT;
      offset_r <= '0;
    end else begin
      tempo_r  <= tempo_nxt;
      rate_r   <= rate_nxt;
      offset_r <= offset_nxt;
    end
  end

  bgq_period_div #(
    .FRACTION_BITS (F),
    .PW            (PW)
  ) u_period_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .recalc (recalc),
    .tempo  (tempo_r),
    .rate   (rate_r),
    .busy   (pdiv_busy),
    .period (period)
  );

  assign busy = pdiv_busy;

  // entry stage
  logic                 accept;
  logic                 s0_vld_r;
  logic [1:0]           s0_mode_r;
  logic signed [W-1:0]  s0_pos_r;
  logic signed [W:0]    s0_diff_r;
  logic [PPW-1:0]       s0_period_r;
  logic [PPW-1:0]       sel_period;

  assign accept = start & ~busy;

  always_comb begin
    if (in_mode == bgq_pkg::MODE_BAR || in_mode == bgq_pkg::MODE_BAR_IDX) begin
      sel_period = PPW'(period) * PPW'(BEATS_PER_BAR);
    end else begin
      sel_period = PPW'(period);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_mode_r   <= in_mode;
    s0_pos_r    <= in_sample_position;
    s0_diff_r   <= (W+1)'(XW'(in_sample_position) - XW'(offset_r));
    s0_period_r <= sel_period;
  end

  logic signed [XW-1:0] diff_x, rel_x, mag_x;
  logic                 neg0;

  always_comb begin
    diff_x = XW'(s0_diff_r);
    priority if (diff_x > bgq_pkg::I64_HI) begin
      rel_x = bgq_pkg::I64_HI;
    end else if (diff_x < bgq_pkg::I64_LO) begin
      rel_x = bgq_pkg::I64_LO;
    end else begin
      rel_x = diff_x;
    end
    neg0  = rel_x[XW-1];
    mag_x = neg0 ? -rel_x : rel_x;
  end

  // division chain
  logic           c_vld    [NQ+1];
  logic [PPW-1:0] c_rem    [NQ+1];
  logic [NQ-1:0]  c_sh     [NQ+1];
  logic [MB-1:0]  c_qm     [NQ+1];
  logic [PPW-1:0] c_period [NQ+1];
  logic [SBW-1:0] c_side   [NQ+1];

  assign c_vld[0]    = s0_vld_r;
  assign c_rem[0]    = '0;
  assign c_sh[0]     = {mag_x[W-1:0], {F{1'b0}}};
  assign c_qm[0]     = '0;
  assign c_period[0] = s0_period_r;
  assign c_side[0]   = {s0_mode_r, s0_pos_r, rel_x[RW-1:0], neg0};

  for (genvar i = 0; i < NQ; i++) begin : g_cell
    bgq_div_cell #(
      .NQ  (NQ),
      .PPW (PPW),
      .MB  (MB),
      .BPB (BEATS_PER_BAR),
      .SBW (SBW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .prev_vld    (c_vld[i]),
      .prev_rem    (c_rem[i]),
      .prev_sh     (c_sh[i]),
      .prev_qm     (c_qm[i]),
      .prev_period (c_period[i]),
      .prev_side   (c_side[i]),
      .next_vld    (c_vld[i+1]),
      .next_rem    (c_rem[i+1]),
      .next_sh     (c_sh[i+1]),
      .next_qm     (c_qm[i+1]),
      .next_period (c_period[i+1]),
      .next_side   (c_side[i+1])
    );
  end

  // stage A: floor remainder, snap distance, quotient saturation
  logic [1:0]           e_mode;
  logic signed [W-1:0]  e_pos;
  logic signed [RW-1:0] e_rel;
  logic                 e_neg;
  logic [PPW-1:0]       e_r, e_p, fr, snap_dist;
  logic [NQ-1:0]        e_q;
  logic                 qbig;

  assign {e_mode, e_pos, e_rel, e_neg} = c_side[NQ];
  assign e_r = c_rem[NQ];
  assign e_p = c_period[NQ];
  assign e_q = c_sh[NQ];

  always_comb begin
    fr        = (e_neg && e_r != '0) ? e_p - e_r : e_r;
    snap_dist = e_p - fr;
    qbig      = QXW'(e_q) > QXW'(bgq_pkg::I64_HI);
  end

  logic                 a_vld_r;
  logic [1:0]           a_mode_r;
  logic signed [W-1:0]  a_pos_r;
  logic signed [RW-1:0] a_rel_r;
  logic                 a_neg_r;
  logic                 a_keep_r;
  logic [DQW-1:0]       a_dq_r;
  logic                 a_dfrac_r;
  logic [QSW-1:0]       a_qs_r;
  logic [MB-1:0]        a_qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= c_vld[NQ];
    end
  end

  always_ff @(posedge clk) begin
    a_mode_r  <= e_mode;
    a_pos_r   <= e_pos;
    a_rel_r   <= e_rel;
    a_neg_r   <= e_neg;
    a_keep_r  <= fr < (PPW'(1) << F);
    a_dq_r    <= snap_dist[PPW-1:F];
    a_dfrac_r <= |snap_dist[F-1:0];
    a_qs_r    <= qbig ? {QSW{1'b1}} : e_q[QSW-1:0];
    a_qm_r    <= qbig ? QSAT_MOD : c_qm[NQ];
  end

  // stage B: snapped distance, counts
  logic signed [XW-1:0] s1_x, sc_x, s2_x, cnt_x, cntc_x, beat_x;

  always_comb begin
    s1_x = XW'(a_rel_r) + XW'(a_dq_r);
    priority if (s1_x > bgq_pkg::I64_HI) begin
      sc_x = bgq_pkg::I64_HI;
    end else if (s1_x < bgq_pkg::I64_LO) begin
      sc_x = bgq_pkg::I64_LO;
    end else begin
      sc_x = s1_x;
    end
    s2_x  = (sc_x[XW-1] && a_dfrac_r) ? sc_x + XW'(1) : sc_x;
    cnt_x = a_neg_r ? -XW'(a_qs_r) : XW'(a_qs_r);
    priority if (cnt_x > POS_HI) begin
      cntc_x = POS_HI;
    end else if (cnt_x < POS_LO) begin
      cntc_x = POS_LO;
    end else begin
      cntc_x = cnt_x;
    end
    beat_x = a_neg_r ? -XW'(a_qm_r) : XW'(a_qm_r);
  end

  logic                 b_vld_r;
  logic [1:0]           b_mode_r;
  logic signed [W-1:0]  b_pos_r;
  logic                 b_keep_r;
  logic signed [63:0]   b_s_r;
  logic signed [W-1:0]  b_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_mode_r <= a_mode_r;
    b_pos_r  <= a_pos_r;
    b_keep_r <= a_keep_r;
    b_s_r    <= s2_x[63:0];
    if (a_mode_r == bgq_pkg::MODE_BAR_IDX) begin
      b_cnt_r <= cntc_x[W-1:0];
    end else begin
      b_cnt_r <= beat_x[W-1:0];
    end
  end

  // stage C: add offset back, select, saturate
  logic signed [XW-1:0] res_x, resc_x;
  logic signed [W-1:0]  val_nxt;
  logic                 out_valid_r;
  logic signed [W-1:0]  out_grid_value_r;

  always_comb begin
    res_x = XW'(offset_r) + XW'(b_s_r);
    priority if (res_x > POS_HI) begin
      resc_x = POS_HI;
    end else if (res_x < POS_LO) begin
      resc_x = POS_LO;
    end else begin
      resc_x = res_x;
    end
    if (b_mode_r == bgq_pkg::MODE_BAR || b_mode_r == bgq_pkg::MODE_BEAT) begin
      val_nxt = b_keep_r ? b_pos_r : resc_x[W-1:0];
    end else begin
      val_nxt = b_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_grid_value_r <= val_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_grid_value = out_grid_value_r;

endmodule

// ===== rtl/bgq_checker.sv =====
// Port-level checks for beat_grid_quantizer_core, bound to the top level.
// Depends on bgq_pkg and beat_grid_quantizer_core.
module bgq_checker #(
  parameter int POSITION_WIDTH = bgq_pkg::POSITION_WIDTH,
  parameter int FRACTION_BITS  = bgq_pkg::FRACTION_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          cfg_we,
  input logic [bgq_pkg::CFG_IDX_W-1:0] cfg_index
);

  localparam int LAT = POSITION_WIDTH + FRACTION_BITS + 4;

  logic accept;
  logic recalc_wr;
  logic offset_wr;

  assign accept    = start & ~busy;
  assign recalc_wr = cfg_we && (cfg_index == bgq_pkg::CFG_TEMPO ||
                                cfg_index == bgq_pkg::CFG_RATE);
  assign offset_wr = cfg_we && cfg_index == bgq_pkg::CFG_OFFSET;

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("transfer accepted without a result at fixed latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    !$past(accept, LAT) |-> !out_valid)
    else $error("result strobe without an earlier transfer");

  a_recalc_busy : assert property (@(posedge clk) disable iff (!rst_n)
    recalc_wr |=> busy)
    else $error("tempo or rate write did not raise busy");

  a_offset_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && offset_wr) |=> !busy)
    else $error("offset write raised busy");

  a_reset_clear : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind beat_grid_quantizer_core bgq_checker #(
  .POSITION_WIDTH (POSITION_WIDTH),
  .FRACTION_BITS  (FRACTION_BITS)
) u_bgq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
